@@ src/signed_int_to_decimal_ascii_top_assert.svh @@
// assertion macros for the signed integer to decimal text block
// expects clk and rst_n in the scope of each use
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define S2DA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define S2DA_NEVER(lbl, expr, msg) \
  `S2DA_ASSERT(lbl, !(expr), msg)
`else
`define S2DA_ASSERT(lbl, prop, msg)
`define S2DA_NEVER(lbl, expr, msg)
`endif
`endif

@@ src/s2da_pkg.sv @@
// shared types and constants for the signed integer to decimal text block
// no dependencies
package s2da_pkg;

  localparam int VALUE_BITS = 32;
  // digits of the largest magnitude 2^(VALUE_BITS-1)
  localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_BITS = 4 * NUM_DIGITS;
  localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);
  localparam int DIG_CNT_BITS = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
  localparam int CHAR_BITS = 6;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;

  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } back_state_t;

endpackage

@@ src/s2da_front.sv @@
// front end: takes a number, splits it into sign and unsigned magnitude
// depends on s2da_pkg
module s2da_front import s2da_pkg::*; (
  input  logic                         start,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  fifo_stat_t                   stat,
  output logic                         busy,
  output logic                         push,
  output item_t                        item
);

  logic [VALUE_BITS-1:0] raw;

  assign raw = in_value;
  assign busy = stat.full;
  assign push = start & ~stat.full;
  assign item.neg = raw[VALUE_BITS-1];
  // most negative value wraps to 2^(VALUE_BITS-1), correct as unsigned
  assign item.mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

endmodule

@@ src/s2da_fifo.sv @@
// short queue of classified words between front and back
// depends on s2da_pkg and the assertion header
`include "signed_int_to_decimal_ascii_top_assert.svh"
module s2da_fifo import s2da_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  item_t      wr_item,
  input  logic       pop,
  output item_t      rd_item,
  output fifo_stat_t stat
);

  item_t                    mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                     do_push, do_pop;

  assign stat.full = (cnt_r == FIFO_CNT_BITS'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push = push & ~stat.full;
  assign do_pop = pop & ~stat.empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  `S2DA_NEVER(a_fifo_cnt_range, cnt_r > FIFO_CNT_BITS'(FIFO_DEPTH), "fifo count overflow")
  `S2DA_ASSERT(a_fifo_push_full, stat.full && push && !pop |=> stat.full, "fifo lost full state")

endmodule

@@ src/s2da_back.sv @@
// back end: shift-and-add-3 binary to bcd, then emits sign and digits
// depends on s2da_pkg and the assertion header
`include "signed_int_to_decimal_ascii_top_assert.svh"
module s2da_back import s2da_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  item_t                rd_item,
  input  fifo_stat_t           stat,
  output logic                 pop,
  output logic                 out_valid,
  output logic [CHAR_BITS-1:0] out_char_code,
  output logic                 out_last_char
);

  back_state_t             state_r, state_nxt;
  logic [VALUE_BITS-1:0]   mag_r;
  logic [BCD_BITS-1:0]     bcd_r;
  logic [BCD_BITS-1:0]     bcd_adj;
  logic                    neg_r;
  logic                    started_r;
  logic [BIT_CNT_BITS-1:0] bit_cnt_r;
  logic [DIG_CNT_BITS-1:0] dig_cnt_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_BITS-1:0]    char_r, char_nxt;
  logic                    last_r, last_nxt;
  logic [3:0]              top_dig;
  logic                    conv_done;
  logic                    dig_last;
  logic                    show_dig;

  function automatic logic [BCD_BITS-1:0] add3(input logic [BCD_BITS-1:0] b);
    logic [BCD_BITS-1:0] r;
    r = b;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  assign bcd_adj = add3(bcd_r);
  assign top_dig = bcd_r[BCD_BITS-1 -: 4];
  assign conv_done = (bit_cnt_r == BIT_CNT_BITS'(VALUE_BITS - 1));
  assign dig_last = (dig_cnt_r == '0);
  // skip leading zeros but always print the units digit
  assign show_dig = started_r | (top_dig != 4'd0) | dig_last;
  assign pop = (state_r == ST_IDLE) & ~stat.empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!stat.empty) state_nxt = ST_CONV;
      ST_CONV: if (conv_done) state_nxt = neg_r ? ST_SIGN : ST_EMIT;
      ST_SIGN: state_nxt = ST_EMIT;
      ST_EMIT: if (dig_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    char_nxt = char_r;
    last_nxt = last_r;
    unique case (state_r)
      ST_SIGN: begin
        out_valid_nxt = 1'b1;
        char_nxt = ASCII_MINUS;
        last_nxt = 1'b0;
      end
      ST_EMIT: begin
        out_valid_nxt = show_dig;
        char_nxt = ASCII_ZERO + {2'b00, top_dig};
        last_nxt = dig_last;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    unique case (state_r)
      ST_IDLE: begin
        mag_r <= rd_item.mag;
        neg_r <= rd_item.neg;
        bcd_r <= '0;
        bit_cnt_r <= '0;
        started_r <= 1'b0;
        dig_cnt_r <= DIG_CNT_BITS'(NUM_DIGITS - 1);
      end
      ST_CONV: begin
        bcd_r <= {bcd_adj[BCD_BITS-2:0], mag_r[VALUE_BITS-1]};
        mag_r <= {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_r <= bit_cnt_r + 1'b1;
      end
      ST_EMIT: begin
        bcd_r <= {bcd_r[BCD_BITS-5:0], 4'd0};
        started_r <= show_dig;
        dig_cnt_r <= dig_cnt_r - 1'b1;
      end
      default: begin
        started_r <= 1'b0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r & out_valid_r;

  `S2DA_ASSERT(a_back_out_src, out_valid_r |-> ($past(state_r) == ST_SIGN || $past(state_r) == ST_EMIT), "strobe outside emit")
  `S2DA_ASSERT(a_back_last_idle, out_valid_r && last_r |-> state_r == ST_IDLE, "last char not at end of run")

endmodule

@@ src/signed_int_to_decimal_ascii_top.sv @@
// a negative value gets a minus sign ahead of its digits; leading zero slots are walked
//   but not shown, so a shorter number shows its first digit later in the run
// the queue takes new words until full; the back end handles one number at a time:
//   pop, bit-per-cycle bcd loop, minus sign if negative, then all ten digit slots
// results cannot be stalled; each character is strobed by out_valid for one cycle
// synchronous active-low reset empties the queue and idles the back end
// depends on s2da_pkg, s2da_front, s2da_fifo, s2da_back
module signed_int_to_decimal_ascii_top import s2da_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  output logic [CHAR_BITS-1:0]         out_char_code,
  output logic                         out_last_char
);

  fifo_stat_t stat;
  item_t      wr_item, rd_item;
  logic       push, pop;

  s2da_front u_front (
    .start    (start),
    .in_value (in_value),
    .stat     (stat),
    .busy     (busy),
    .push     (push),
    .item     (wr_item)
  );

  s2da_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .stat    (stat)
  );

  s2da_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_item       (rd_item),
    .stat          (stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

@@ tb/sv/signed_int_to_decimal_ascii_top_tb.sv @@
// testbench for signed_int_to_decimal_ascii_top: signed 32-bit words in, decimal ascii chars out
// a scoreboard class predicts the character string of every accepted word and checks each strobe
// depends on s2da_pkg and the signed_int_to_decimal_ascii_top rtl
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_top_tb;
  import s2da_pkg::*;

  typedef struct packed {
    logic [CHAR_BITS-1:0] code;
    logic                 last;
  } char_word_t;

  class text_scoreboard;
    char_word_t pending_chars[$];
    int         mismatches = 0;

    // expand one accepted word into its expected characters
    function void note_value(input logic [VALUE_BITS-1:0] v);
      logic [VALUE_BITS-1:0] mag;
      logic [3:0]            digs[$];
      char_word_t            w;
      bit                    neg;
      neg = v[VALUE_BITS-1];
      // unsigned magnitude, so the most negative word still comes out right
      mag = neg ? (~v + 1'b1) : v;
      do begin
        digs.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (neg) begin
        w.code = ASCII_MINUS;
        w.last = 1'b0;
        pending_chars.push_back(w);
      end
      foreach (digs[i]) begin
        w.code = ASCII_ZERO + CHAR_BITS'(digs[i]);
        w.last = (i == digs.size() - 1);
        pending_chars.push_back(w);
      end
    endfunction

    function void check_char(input logic [CHAR_BITS-1:0] code, input logic last);
      char_word_t w;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char, expected none, got %0d last %0b", $time, code, last);
        mismatches++;
      end else begin
        w = pending_chars.pop_front();
        if (code !== w.code) begin
          $display("%0t: char code wrong, expected %0d, got %0d", $time, w.code, code);
          mismatches++;
        end
        if (last !== w.last) begin
          $display("%0t: last flag wrong, expected %0b, got %0b", $time, w.last, last);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         out_valid;
  logic [CHAR_BITS-1:0]         out_char_code;
  logic                         out_last_char;

  text_scoreboard sb;
  bit             burst_mode;

  signed_int_to_decimal_ascii_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // note the accepted word first so a same-edge result still finds its expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_value(in_value);
      if (out_valid) sb.check_char(out_char_code, out_last_char);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 70);
  endfunction

  // offer one word, hold it until taken, then idle for the requested gap
  task automatic send_word(input logic [VALUE_BITS-1:0] v, input int gap);
    @(negedge clk);
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      @(negedge clk);
      start    <= 1'b0;
      in_value <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic logic [VALUE_BITS-1:0] random_word();
    int unsigned p;
    int unsigned m;
    int          k;
    p = 1;
    k = $urandom_range(1, 9);
    repeat (k) p = p * 10;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: m = $urandom_range(0, p - 1);
      3: m = $urandom_range(0, 1) ? p : p - 1;
      4: m = $urandom_range(0, 20);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h8000_0001;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  logic [VALUE_BITS-1:0] directed[$] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100, -32'sd9,
    32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
    -32'sd999999999, -32'sd1000000000, 32'h5555_5555, 32'haaaa_aaaa,
    32'd1234567890, 32'd4096
  };

  initial begin
    sb       = new;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    burst_mode = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_word(directed[i], pick_gap());

    for (int i = 0; i < 200; i++) begin
      // alternate stretches of back-to-back words with gappy ones
      if (i % 16 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_word(random_word(), pick_gap());
    end
    @(negedge clk);
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/s2da_pkg.sv
src/s2da_front.sv
src/s2da_fifo.sv
src/s2da_back.sv
src/signed_int_to_decimal_ascii_top.sv
tb/sv/signed_int_to_decimal_ascii_top_tb.sv
